// ===== design/bascule_bridge_sequencer_defines.svh =====
// Assertion helpers for the bridge sequencer
`ifndef BASCULE_BRIDGE_SEQUENCER_DEFINES_SVH
`define BASCULE_BRIDGE_SEQUENCER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define BBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication in the next cycle
`define BBS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/bbs_pkg.sv =====
package bbs_pkg;

    localparam int TimerBits = 20;
    localparam int QueueDepth = 4;
    localparam int QueueIdxBits = 2;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_STOPPING  = 4'd1,
        ST_OPENING   = 4'd2,
        ST_OPEN      = 4'd3,
        ST_CLOSING   = 4'd4,
        ST_RESUMING  = 4'd5,
        ST_FAULT     = 4'd6,
        ST_MANUAL    = 4'd7,
        ST_M_OPENING = 4'd8,
        ST_M_OPEN    = 4'd9,
        ST_M_CLOSING = 4'd10,
        ST_M_CLOSED  = 4'd11
    } bridge_state_t;

    typedef enum logic [4:0] {
        EV_TICK = 5'd0, EV_RESET = 5'd1, EV_FAULT = 5'd2, EV_TIMEOUT = 5'd3,
        EV_OVR_ON = 5'd4, EV_OVR_OFF = 5'd5, EV_BEAM_ON = 5'd6, EV_BEAM_OFF = 5'd7,
        EV_DET = 5'd8, EV_DET_L = 5'd9, EV_DET_R = 5'd10, EV_PASSED = 5'd11,
        EV_STOPPED = 5'd12, EV_OPENED = 5'd13, EV_CLOSED = 5'd14,
        EV_RESUMED = 5'd15, EV_FAULT_CLR = 5'd16, EV_M_OPEN = 5'd17,
        EV_M_CLOSE = 5'd18, EV_M_STOP = 5'd19, EV_M_RESUME = 5'd20
    } event_t;

    typedef enum logic [3:0] {
        A_STATE = 4'd0, A_STOP = 4'd1, A_RESUME = 4'd2, A_RAISE = 4'd3,
        A_LOWER = 4'd4, A_LG = 4'd5, A_LR = 4'd6, A_RG = 4'd7, A_RR = 4'd8,
        A_SAFE = 4'd9, A_IDLE = 4'd10, A_OPP_LR = 4'd11, A_OPP_RL = 4'd12,
        A_DET_RESET = 4'd13, A_ALL_SENS = 4'd14
    } action_t;

    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_LEFT = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    localparam logic [1:0] DEF_NONE = 2'd0;
    localparam logic [1:0] DEF_AUTO = 2'd1;
    localparam logic [1:0] DEF_MANUAL = 2'd2;

    localparam logic [1:0] REG_PASSAGE = 2'd0;
    localparam logic [1:0] REG_CLEARANCE = 2'd1;
    localparam logic [1:0] REG_DETLINK = 2'd2;

    // Classified event handed from front to back
    typedef struct packed {
        logic [4:0] kind;
        logic [1:0] side;
    } bbs_event_t;

    // One result item
    typedef struct packed {
        logic [3:0] action;
        logic [3:0] bridge_state;
        logic [3:0] prior_state;
        logic       last_of_run;
    } bbs_result_t;

endpackage

// ===== design/bbs_front.sv =====
module bbs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [4:0]          kind,
    input  logic [1:0]          boat_side,
    output logic                ev_valid,
    input  logic                ev_take,
    output bbs_pkg::bbs_event_t ev_head
);

    bbs_pkg::bbs_event_t mem [bbs_pkg::QueueDepth];
    logic [bbs_pkg::QueueIdxBits-1:0] wr_reg;
    logic [bbs_pkg::QueueIdxBits-1:0] rd_reg;
    logic [bbs_pkg::QueueIdxBits:0]   cnt_reg;
    logic [bbs_pkg::QueueIdxBits:0]   cnt_next;
    logic do_push;

    assign full    = (cnt_reg == (bbs_pkg::QueueIdxBits+1)'(bbs_pkg::QueueDepth));
    assign do_push = push && !full;
    assign ev_valid = (cnt_reg != '0);
    assign ev_head  = mem[rd_reg];

    // Count entries in flight
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !ev_take)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && ev_take)
            cnt_next = cnt_reg - 1'b1;
    end

    // Store classified events
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg].kind <= kind;
            mem[wr_reg].side <= (boat_side == 2'd3) ? bbs_pkg::SIDE_NONE : boat_side;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (ev_take)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/bbs_back.sv =====
module bbs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ev_valid,
    output logic                 ev_take,
    input  bbs_pkg::bbs_event_t  ev_head,
    input  logic [19:0]          passage_ticks,
    input  logic [19:0]          clearance_ticks,
    input  logic                 det_link,
    input  logic                 pop,
    output logic                 empty,
    output bbs_pkg::bbs_result_t res_head
);

    localparam logic [bbs_pkg::TimerBits-1:0] TMax = '1;

    bbs_pkg::bridge_state_t cur_reg, cur_next, prv_reg, prv_next;
    logic [1:0] act_reg, act_next, lat_reg, lat_next, def_reg, def_next;
    logic cyc_reg, cyc_next, awt_reg, awt_next, opp_reg, opp_next;
    logic beam_reg, beam_next, otr_reg, otr_next;
    logic [bbs_pkg::TimerBits-1:0] oel_reg, oel_next, cel_reg, cel_next;

    // Result buffer: one batch per event
    bbs_pkg::bbs_result_t buf_reg [4];
    bbs_pkg::bbs_result_t buf_next [4];
    logic [2:0] bcnt_reg, bcnt_next;
    logic [1:0] bidx_reg;
    bbs_pkg::bbs_result_t nb [4];
    logic [2:0] nc;

    logic busy;
    assign busy    = (bcnt_reg != '0);
    assign empty   = !busy;
    assign res_head = buf_reg[bidx_reg];
    // Take a new event when the buffer is empty or its last item leaves now
    assign ev_take = ev_valid && (!busy || (pop && bcnt_reg == 3'd1));

    // Event evaluation (one event per take)
    always_comb
    begin
        logic [4:0] k;
        logic [1:0] s;
        logic [1:0] opp;
        logic seen;
        logic [3:0] lact;
        logic [1:0] ldef;
        logic lman;
        logic do_lower;
        logic do_fault;
        k = ev_head.kind;
        s = ev_head.side;
        opp = 2'd0;
        seen = 1'b0;
        do_lower = 1'b0;
        do_fault = 1'b0;
        lman = 1'b0;
        lact = 4'd0;
        ldef = 2'd0;
        cur_next = cur_reg; prv_next = prv_reg;
        act_next = act_reg; lat_next = lat_reg; def_next = def_reg;
        cyc_next = cyc_reg; awt_next = awt_reg; opp_next = opp_reg;
        beam_next = beam_reg; otr_next = otr_reg;
        oel_next = oel_reg; cel_next = cel_reg;
        nc = 3'd0;
        for (int i = 0; i < 4; i++)
            nb[i] = '0;

        // The helpers below are spelled out inline, in the model's order
        if (k == bbs_pkg::EV_TICK)
        begin
            if (otr_next && oel_next != TMax) oel_next = oel_next + 1'b1;
            if (awt_next && cel_next != TMax) cel_next = cel_next + 1'b1;
            if (cur_next == bbs_pkg::ST_OPEN && otr_next && oel_next >= passage_ticks)
            begin
                // fault entry
                act_next = bbs_pkg::SIDE_NONE; cyc_next = 1'b0; otr_next = 1'b0;
                oel_next = '0; cel_next = '0; awt_next = 1'b0; opp_next = 1'b0;
                lat_next = bbs_pkg::SIDE_NONE; def_next = bbs_pkg::DEF_NONE;
                beam_next = 1'b0;
                if (det_link)
                begin
                    nb[nc[1:0]] = {bbs_pkg::A_ALL_SENS, cur_next, prv_next, 1'b0};
                    nc = nc + 1'b1;
                end
                prv_next = cur_next; cur_next = bbs_pkg::ST_FAULT;
                nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0}; nc = nc + 1'b1;
                nb[nc[1:0]] = {bbs_pkg::A_SAFE, cur_next, prv_next, 1'b0}; nc = nc + 1'b1;
            end
            if (awt_next && cel_next >= clearance_ticks)
            begin
                seen = opp_next;
                awt_next = 1'b0; cel_next = '0; opp_next = 1'b0;
                if (seen)
                begin
                    do_lower = 1'b1;
                    lman = 1'b0;
                end
                else if (cur_next != bbs_pkg::ST_FAULT)
                    do_fault = 1'b1;
            end
        end
        else
        begin
            if (k == bbs_pkg::EV_BEAM_ON) beam_next = 1'b1;
            else if (k == bbs_pkg::EV_BEAM_OFF) beam_next = 1'b0;
            if (s != bbs_pkg::SIDE_NONE)
            begin
                lat_next = s;
                if ((k == bbs_pkg::EV_DET || k == bbs_pkg::EV_DET_L ||
                     k == bbs_pkg::EV_DET_R) && !cyc_next)
                    act_next = s;
            end
            if (k == bbs_pkg::EV_RESET)
            begin
                act_next = bbs_pkg::SIDE_NONE; cyc_next = 1'b0; otr_next = 1'b0;
                oel_next = '0; cel_next = '0; awt_next = 1'b0; opp_next = 1'b0;
                lat_next = bbs_pkg::SIDE_NONE; def_next = bbs_pkg::DEF_NONE;
                beam_next = 1'b0;
                if (det_link)
                begin
                    nb[nc[1:0]] = {bbs_pkg::A_ALL_SENS, cur_next, prv_next, 1'b0};
                    nc = nc + 1'b1;
                end
                if (cur_next != bbs_pkg::ST_IDLE)
                begin
                    prv_next = cur_next; cur_next = bbs_pkg::ST_IDLE;
                end
                nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0}; nc = nc + 1'b1;
                nb[nc[1:0]] = {bbs_pkg::A_IDLE, cur_next, prv_next, 1'b0}; nc = nc + 1'b1;
            end
            else if (k == bbs_pkg::EV_FAULT || k == bbs_pkg::EV_TIMEOUT)
            begin
                if (cur_next != bbs_pkg::ST_FAULT) do_fault = 1'b1;
            end
            else if (k == bbs_pkg::EV_OVR_ON)
            begin
                if (cur_next != bbs_pkg::ST_MANUAL)
                begin
                    prv_next = cur_next; cur_next = bbs_pkg::ST_MANUAL;
                    nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                    nc = nc + 1'b1;
                end
            end
            else if (k == bbs_pkg::EV_BEAM_ON)
            begin
                nc = nc;
            end
            else if (k == bbs_pkg::EV_BEAM_OFF)
            begin
                if (def_next == bbs_pkg::DEF_AUTO)
                begin
                    do_lower = 1'b1; lman = 1'b0;
                end
                else if (def_next == bbs_pkg::DEF_MANUAL)
                begin
                    do_lower = 1'b1; lman = 1'b1;
                end
            end
            else if (k == bbs_pkg::EV_DET_L || k == bbs_pkg::EV_DET_R)
            begin
                if (awt_next && act_next != bbs_pkg::SIDE_NONE)
                begin
                    opp = (act_next == bbs_pkg::SIDE_LEFT) ? bbs_pkg::SIDE_RIGHT
                                                           : bbs_pkg::SIDE_LEFT;
                    if (lat_next == opp) opp_next = 1'b1;
                end
                if (!(lat_next == bbs_pkg::SIDE_NONE || cyc_next ||
                      cur_next != bbs_pkg::ST_IDLE))
                begin
                    cyc_next = 1'b1;
                    act_next = lat_next;
                    prv_next = cur_next; cur_next = bbs_pkg::ST_STOPPING;
                    nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0}; nc = nc + 1'b1;
                    nb[nc[1:0]] = {bbs_pkg::A_STOP, cur_next, prv_next, 1'b0}; nc = nc + 1'b1;
                end
            end
            else if (k == bbs_pkg::EV_DET)
            begin
                nc = nc;
            end
            else
            begin
                unique case (cur_next)
                    bbs_pkg::ST_IDLE, bbs_pkg::ST_M_OPEN, bbs_pkg::ST_M_CLOSED:
                    begin
                        if (k == bbs_pkg::EV_M_OPEN && cur_next != bbs_pkg::ST_M_OPEN)
                        begin
                            prv_next = cur_next; cur_next = bbs_pkg::ST_M_OPENING;
                            nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                            nb[nc[1:0]] = {bbs_pkg::A_RAISE, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                        end
                        else if (cur_next != bbs_pkg::ST_M_CLOSED)
                        begin
                            if (k == bbs_pkg::EV_M_CLOSE)
                            begin
                                do_lower = 1'b1; lman = 1'b1;
                            end
                            else if (k == bbs_pkg::EV_M_STOP)
                            begin
                                nb[nc[1:0]] = {bbs_pkg::A_STOP, cur_next, prv_next, 1'b0};
                                nc = nc + 1'b1;
                            end
                            else if (k == bbs_pkg::EV_M_RESUME)
                            begin
                                nb[nc[1:0]] = {bbs_pkg::A_RESUME, cur_next, prv_next, 1'b0};
                                nc = nc + 1'b1;
                            end
                        end
                    end
                    bbs_pkg::ST_STOPPING:
                        if (k == bbs_pkg::EV_STOPPED)
                        begin
                            prv_next = cur_next; cur_next = bbs_pkg::ST_OPENING;
                            nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                            nb[nc[1:0]] = {bbs_pkg::A_RAISE, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                        end
                    bbs_pkg::ST_OPENING:
                        if (k == bbs_pkg::EV_OPENED)
                        begin
                            prv_next = cur_next; cur_next = bbs_pkg::ST_OPEN;
                            nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                            otr_next = 1'b1; oel_next = '0;
                            if (act_next == bbs_pkg::SIDE_LEFT)
                            begin
                                nb[nc[1:0]] = {bbs_pkg::A_LG, cur_next, prv_next, 1'b0};
                                nc = nc + 1'b1;
                            end
                            else if (act_next == bbs_pkg::SIDE_RIGHT)
                            begin
                                nb[nc[1:0]] = {bbs_pkg::A_RG, cur_next, prv_next, 1'b0};
                                nc = nc + 1'b1;
                            end
                        end
                    bbs_pkg::ST_OPEN:
                        if (k == bbs_pkg::EV_PASSED)
                        begin
                            nb[nc[1:0]] = {bbs_pkg::A_LR, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                            nb[nc[1:0]] = {bbs_pkg::A_RR, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                            if (det_link && act_next != bbs_pkg::SIDE_NONE)
                            begin
                                lact = (act_next == bbs_pkg::SIDE_LEFT) ? bbs_pkg::A_OPP_LR
                                                                        : bbs_pkg::A_OPP_RL;
                                nb[nc[1:0]] = {lact, cur_next, prv_next, 1'b0};
                                nc = nc + 1'b1;
                                nb[nc[1:0]] = {bbs_pkg::A_DET_RESET, cur_next, prv_next, 1'b0};
                                nc = nc + 1'b1;
                            end
                            awt_next = 1'b1; cel_next = '0; opp_next = 1'b0;
                        end
                    bbs_pkg::ST_CLOSING:
                        if (k == bbs_pkg::EV_CLOSED)
                        begin
                            prv_next = cur_next; cur_next = bbs_pkg::ST_RESUMING;
                            nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                            nb[nc[1:0]] = {bbs_pkg::A_RESUME, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                        end
                    bbs_pkg::ST_RESUMING:
                        if (k == bbs_pkg::EV_RESUMED)
                        begin
                            if (det_link)
                            begin
                                nb[nc[1:0]] = {bbs_pkg::A_ALL_SENS, cur_next, prv_next, 1'b0};
                                nc = nc + 1'b1;
                            end
                            act_next = bbs_pkg::SIDE_NONE; cyc_next = 1'b0; otr_next = 1'b0;
                            oel_next = '0; cel_next = '0; awt_next = 1'b0; opp_next = 1'b0;
                            prv_next = cur_next; cur_next = bbs_pkg::ST_IDLE;
                            nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                        end
                    bbs_pkg::ST_FAULT:
                        if (k == bbs_pkg::EV_FAULT_CLR)
                        begin
                            prv_next = cur_next; cur_next = bbs_pkg::ST_IDLE;
                            nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                        end
                    bbs_pkg::ST_MANUAL:
                        if (k == bbs_pkg::EV_OVR_OFF)
                        begin
                            prv_next = cur_next; cur_next = bbs_pkg::ST_IDLE;
                            nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                        end
                    bbs_pkg::ST_M_OPENING:
                        if (k == bbs_pkg::EV_OPENED)
                        begin
                            prv_next = cur_next; cur_next = bbs_pkg::ST_M_OPEN;
                            nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                        end
                    bbs_pkg::ST_M_CLOSING:
                        if (k == bbs_pkg::EV_CLOSED)
                        begin
                            prv_next = cur_next; cur_next = bbs_pkg::ST_IDLE;
                            nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                            nc = nc + 1'b1;
                        end
                    default: nc = nc;
                endcase
            end
        end

        // Fault entry requested by a global event or the clearance check
        if (do_fault)
        begin
            act_next = bbs_pkg::SIDE_NONE; cyc_next = 1'b0; otr_next = 1'b0;
            oel_next = '0; cel_next = '0; awt_next = 1'b0; opp_next = 1'b0;
            lat_next = bbs_pkg::SIDE_NONE; def_next = bbs_pkg::DEF_NONE;
            beam_next = 1'b0;
            if (det_link && nc < 3'd4)
            begin
                nb[nc[1:0]] = {bbs_pkg::A_ALL_SENS, cur_next, prv_next, 1'b0};
                nc = nc + 1'b1;
            end
            prv_next = cur_next; cur_next = bbs_pkg::ST_FAULT;
            if (nc < 3'd4)
            begin
                nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                nc = nc + 1'b1;
            end
            if (nc < 3'd4)
            begin
                nb[nc[1:0]] = {bbs_pkg::A_SAFE, cur_next, prv_next, 1'b0};
                nc = nc + 1'b1;
            end
        end

        // Lower request: defer while the beam is blocked
        if (do_lower)
        begin
            ldef = lman ? bbs_pkg::DEF_MANUAL : bbs_pkg::DEF_AUTO;
            if (beam_next)
                def_next = ldef;
            else
            begin
                def_next = bbs_pkg::DEF_NONE;
                prv_next = cur_next;
                cur_next = lman ? bbs_pkg::ST_M_CLOSING : bbs_pkg::ST_CLOSING;
                if (nc < 3'd4)
                begin
                    nb[nc[1:0]] = {bbs_pkg::A_STATE, cur_next, prv_next, 1'b0};
                    nc = nc + 1'b1;
                end
                if (nc < 3'd4)
                begin
                    nb[nc[1:0]] = {bbs_pkg::A_LOWER, cur_next, prv_next, 1'b0};
                    nc = nc + 1'b1;
                end
            end
        end

        // Mark the last item of the batch
        if (nc != 3'd0)
            nb[nc[1:0] - 2'd1].last_of_run = 1'b1;
    end

    // Buffer load and drain
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            buf_next[i] = ev_take ? nb[i] : buf_reg[i];
        bcnt_next = bcnt_reg;
        if (ev_take)
            bcnt_next = nc;
        else if (pop && busy)
            bcnt_next = bcnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            buf_reg[i] <= buf_next[i];
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= bbs_pkg::ST_IDLE; prv_reg <= bbs_pkg::ST_IDLE;
            act_reg <= bbs_pkg::SIDE_NONE; lat_reg <= bbs_pkg::SIDE_NONE;
            def_reg <= bbs_pkg::DEF_NONE;
            cyc_reg <= 1'b0; awt_reg <= 1'b0; opp_reg <= 1'b0;
            beam_reg <= 1'b0; otr_reg <= 1'b0;
            oel_reg <= '0; cel_reg <= '0;
            bcnt_reg <= '0; bidx_reg <= '0;
        end
        else
        begin
            if (ev_take)
            begin
                cur_reg <= cur_next; prv_reg <= prv_next;
                act_reg <= act_next; lat_reg <= lat_next; def_reg <= def_next;
                cyc_reg <= cyc_next; awt_reg <= awt_next; opp_reg <= opp_next;
                beam_reg <= beam_next; otr_reg <= otr_next;
                oel_reg <= oel_next; cel_reg <= cel_next;
                bidx_reg <= '0;
            end
            else if (pop && busy)
                bidx_reg <= bidx_reg + 1'b1;
            bcnt_reg <= bcnt_next;
        end
    end

endmodule

// ===== design/bascule_bridge_sequencer.sv =====
// An event is evaluated when the back end takes it, which waits until the result
// buffer is empty or its last item is popped; the results are then registered into it.
// Throughput with pop held: one event per cycle when it causes at most one result;
// otherwise one result item per cycle, set by the four-entry result buffer drain.
// Reset (rst_n low, asynchronous): idle state, queues empty, registers to defaults.
`include "bascule_bridge_sequencer_defines.svh"

module bascule_bridge_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  kind,
    input  logic [1:0]  boat_side,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  action,
    output logic [3:0]  bridge_state,
    output logic [3:0]  prior_state,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic [19:0] passage_reg;
    logic [19:0] clearance_reg;
    logic        detlink_reg;
    logic        ev_valid;
    logic        ev_take;
    bbs_pkg::bbs_event_t  ev_head;
    bbs_pkg::bbs_result_t res_head;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            passage_reg   <= 20'd60000;
            clearance_reg <= 20'd10000;
            detlink_reg   <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bbs_pkg::REG_PASSAGE:   passage_reg   <= cfg_data;
                bbs_pkg::REG_CLEARANCE: clearance_reg <= cfg_data;
                bbs_pkg::REG_DETLINK:   detlink_reg   <= cfg_data[0];
                default:                detlink_reg   <= detlink_reg;
            endcase
        end
    end

    bbs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .kind     (kind),
        .boat_side(boat_side),
        .ev_valid (ev_valid),
        .ev_take  (ev_take),
        .ev_head  (ev_head)
    );

    bbs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ev_valid       (ev_valid),
        .ev_take        (ev_take),
        .ev_head        (ev_head),
        .passage_ticks  (passage_reg),
        .clearance_ticks(clearance_reg),
        .det_link       (detlink_reg),
        .pop            (pop),
        .empty          (empty),
        .res_head       (res_head)
    );

    assign action       = res_head.action;
    assign bridge_state = res_head.bridge_state;
    assign prior_state  = res_head.prior_state;
    assign last_of_run  = res_head.last_of_run;

    `BBS_ASSERT(a_state_range, empty || bridge_state <= 4'd11, "state code out of range")
    `BBS_ASSERT_NEXT(a_full_holds, full && !ev_take, full, "full queue drained without a take")
    `BBS_ASSERT(a_take_valid, !ev_take || ev_valid, "back end took from empty queue")

endmodule
